/* rtl/grid_bfs_shortest_path_defines.svh */
// Assertion macros shared by the grid path search RTL.
// Each macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef GRID_BFS_SHORTEST_PATH_DEFINES_SVH
`define GRID_BFS_SHORTEST_PATH_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define GBFS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define GBFS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define GBFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/gbfs_pkg.sv */
// Shared constants, codes and types of the grid path search block.
// No dependencies; every RTL module file imports this package.
package gbfs_pkg;

  // Grid limits and derived widths.
  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
  localparam int IDX_W      = $clog2(CELL_COUNT);
  localparam int LP_W       = IDX_W + 1;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROWC_W     = $clog2(MAX_ROWS + 1);
  localparam int COLC_W     = $clog2(MAX_COLS + 1);

  // Register and field widths.
  localparam int SIZE_W      = 7;
  localparam int COST_W      = 16;
  localparam int PCOST_W     = 28;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [SIZE_W-1:0] GRID_SIZE_RST = 7'd64;
  localparam logic [COST_W-1:0] STEP_COST_RST = 16'd1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLS = 2'd0,
    REG_GRID_ROWS = 2'd1,
    REG_STEP_COST = 2'd2
  } cfg_reg_e;

  // Cell kinds carried by each input item.
  typedef enum logic [1:0] {
    KIND_WALL  = 2'd0,
    KIND_OPEN  = 2'd1,
    KIND_START = 2'd2,
    KIND_END   = 2'd3
  } cell_kind_e;

  // Neighbor directions, visited in this order.
  typedef enum logic [1:0] {
    DIR_DOWN  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_e;

  // A grid position with its row-major index.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [IDX_W-1:0] idx;
  } pos_t;

  // One search queue entry.
  typedef struct packed {
    logic [IDX_W-1:0] steps;
    pos_t             pos;
  } qent_t;

  // Neighbor step result.
  typedef struct packed {
    logic ok;
    pos_t pos;
  } step_t;

  // Cell write from the loader into the free-cell map.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic             open;
  } ld_wr_t;

  // Search launch request.
  typedef struct packed {
    logic              go;
    logic [IDX_W-1:0]  start_idx;
    logic [IDX_W-1:0]  end_idx;
    logic [LP_W-1:0]   limit;
    logic [ROWC_W-1:0] rows;
    logic [COLC_W-1:0] cols;
  } go_t;

  // Search outcome.
  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] steps;
  } res_t;

endpackage

/* rtl/gbfs_step.sv */
// Shared neighbor step unit: one add/subtract on the cell index plus bounds checks.
// Depends on gbfs_pkg. Also serves the start-cell row division as a subtractor.
module gbfs_step import gbfs_pkg::*; (
  input  pos_t              pos_i,
  input  dir_e              dir_i,
  input  logic [ROWC_W-1:0] rows_i,
  input  logic [COLC_W-1:0] cols_i,
  input  logic [LP_W-1:0]   limit_i,
  output step_t             step_o
);

  logic            sub;
  logic            inb;
  logic [LP_W-1:0] addend;
  logic [LP_W-1:0] nsum;
  pos_t            npos;

  // Select the step for the direction and check the grid border.
  always_comb begin
    sub    = 1'b0;
    inb    = 1'b0;
    addend = LP_W'(cols_i);
    npos   = pos_i;
    case (dir_i)
      DIR_DOWN: begin
        inb      = (ROWC_W'(pos_i.row) + ROWC_W'(1)) < rows_i;
        npos.row = pos_i.row + ROW_W'(1);
      end
      DIR_RIGHT: begin
        addend   = LP_W'(1);
        inb      = (COLC_W'(pos_i.col) + COLC_W'(1)) < cols_i;
        npos.col = pos_i.col + COL_W'(1);
      end
      DIR_UP: begin
        sub      = 1'b1;
        inb      = pos_i.row != '0;
        npos.row = pos_i.row - ROW_W'(1);
      end
      DIR_LEFT: begin
        sub      = 1'b1;
        addend   = LP_W'(1);
        inb      = pos_i.col != '0;
        npos.col = pos_i.col - COL_W'(1);
      end
      default: begin
        inb = 1'b0;
      end
    endcase
  end

  // The one index adder of the unit; cells at or past the load limit count as walls.
  assign nsum        = sub ? (LP_W'(pos_i.idx) - addend) : (LP_W'(pos_i.idx) + addend);
  assign step_o.ok   = inb && (nsum < limit_i);
  assign step_o.pos  = '{row: npos.row, col: npos.col, idx: nsum[IDX_W-1:0]};

endmodule

/* rtl/gbfs_search.sv */
// Breadth-first search sequencer with the free-cell map and the search queue memories.
// Depends on gbfs_pkg, gbfs_step and the assertion macro header.
`include "grid_bfs_shortest_path_defines.svh"

module gbfs_search import gbfs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  ld_wr_t ld_i,
  input  go_t    go_i,
  output res_t   res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SEED,
    S_POP,
    S_NREQ,
    S_NCHK,
    S_FIN
  } state_e;

  state_e            state_q;
  dir_e              dir_q;
  logic [LP_W-1:0]   head_q;
  logic [LP_W-1:0]   tail_q;
  logic [IDX_W-1:0]  rem_q;
  logic [ROW_W-1:0]  row_q;
  logic [IDX_W-1:0]  start_q;
  logic [IDX_W-1:0]  end_q;
  logic [LP_W-1:0]   limit_q;
  logic [ROWC_W-1:0] rows_q;
  logic [COLC_W-1:0] cols_q;
  pos_t              nbr_q;
  logic              found_q;
  logic [IDX_W-1:0]  dist_q;

  // Free-cell map: 1 while a cell is open and not yet reached.
  logic              free_mem [CELL_COUNT];
  logic              free_rd_q;
  logic              free_we;
  logic [IDX_W-1:0]  free_waddr;
  logic              free_wdata;
  logic              free_re;

  // Search queue of reached cells with their distances.
  qent_t             queue_mem [CELL_COUNT];
  qent_t             q_rd_q;
  logic              q_we;
  qent_t             q_wdata;
  logic              q_re;

  pos_t              u_pos;
  dir_e              u_dir;
  step_t             step;
  logic              hit_free;
  logic              hit_end;
  logic [IDX_W-1:0]  dist_next;

  // The shared step unit serves the row division and the neighbor walk.
  always_comb begin
    if (state_q == S_DIV) begin
      u_pos = '{row: '0, col: '0, idx: rem_q};
      u_dir = DIR_UP;
    end else begin
      u_pos = q_rd_q.pos;
      u_dir = dir_q;
    end
  end

  gbfs_step u_step (
    .pos_i   (u_pos),
    .dir_i   (u_dir),
    .rows_i  (rows_q),
    .cols_i  (cols_q),
    .limit_i (limit_q),
    .step_o  (step)
  );

  assign hit_free  = (state_q == S_NCHK) && free_rd_q;
  assign hit_end   = hit_free && (nbr_q.idx == end_q);
  assign dist_next = q_rd_q.steps + IDX_W'(1);

  // Memory port controls.
  always_comb begin
    free_we    = ld_i.en || (state_q == S_SEED) || hit_free;
    free_waddr = ld_i.en ? ld_i.addr : ((state_q == S_SEED) ? start_q : nbr_q.idx);
    free_wdata = ld_i.en ? ld_i.open : 1'b0;
    free_re    = (state_q == S_NREQ) && step.ok;
    q_we       = (state_q == S_SEED) || (hit_free && !hit_end);
    q_re       = (state_q == S_POP) && (head_q != tail_q);
    if (state_q == S_SEED) begin
      q_wdata = '{steps: '0, pos: '{row: row_q, col: COL_W'(rem_q), idx: start_q}};
    end else begin
      q_wdata = '{steps: dist_next, pos: nbr_q};
    end
  end

  // Free-cell map storage.
  always_ff @(posedge clk_i) begin
    if (free_we) begin
      free_mem[free_waddr] <= free_wdata;
    end
    if (free_re) begin
      free_rd_q <= free_mem[step.pos.idx];
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (q_we) begin
      queue_mem[tail_q[IDX_W-1:0]] <= q_wdata;
    end
    if (q_re) begin
      q_rd_q <= queue_mem[head_q[IDX_W-1:0]];
    end
  end

  // Sequencer: divide the start index into row and column, seed, then walk the queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dir_q   <= DIR_DOWN;
      head_q  <= '0;
      tail_q  <= '0;
      rem_q   <= '0;
      row_q   <= '0;
      start_q <= '0;
      end_q   <= '0;
      limit_q <= '0;
      rows_q  <= '0;
      cols_q  <= '0;
      nbr_q   <= '0;
      found_q <= 1'b0;
      dist_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (go_i.go) begin
            start_q <= go_i.start_idx;
            end_q   <= go_i.end_idx;
            limit_q <= go_i.limit;
            rows_q  <= go_i.rows;
            cols_q  <= go_i.cols;
            rem_q   <= go_i.start_idx;
            row_q   <= '0;
            found_q <= 1'b0;
            dist_q  <= '0;
            // The seed entry goes to the front of an empty queue.
            head_q  <= '0;
            tail_q  <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (LP_W'(rem_q) >= LP_W'(cols_q)) begin
            rem_q <= step.pos.idx;
            row_q <= row_q + ROW_W'(1);
          end else begin
            state_q <= S_SEED;
          end
        end
        S_SEED: begin
          head_q  <= '0;
          tail_q  <= LP_W'(1);
          state_q <= S_POP;
        end
        S_POP: begin
          if (head_q == tail_q) begin
            state_q <= S_FIN;
          end else begin
            head_q  <= head_q + LP_W'(1);
            dir_q   <= DIR_DOWN;
            state_q <= S_NREQ;
          end
        end
        S_NREQ: begin
          if (step.ok) begin
            nbr_q   <= step.pos;
            state_q <= S_NCHK;
          end else if (dir_q == DIR_LEFT) begin
            state_q <= S_POP;
          end else begin
            dir_q <= dir_e'(dir_q + 2'd1);
          end
        end
        S_NCHK: begin
          if (hit_end) begin
            found_q <= 1'b1;
            dist_q  <= dist_next;
            state_q <= S_FIN;
          end else begin
            if (hit_free) begin
              tail_q <= tail_q + LP_W'(1);
            end
            if (dir_q == DIR_LEFT) begin
              state_q <= S_POP;
            end else begin
              dir_q   <= dir_e'(dir_q + 2'd1);
              state_q <= S_NREQ;
            end
          end
        end
        S_FIN: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_o = '{done: (state_q == S_FIN), found: found_q, steps: dist_q};

  // The queue never reads past what it has written.
  `GBFS_ASSERT_ALWAYS(a_head_le_tail, head_q <= tail_q, "queue head passed tail")
  // Each cell enters the queue once, so the queue cannot overflow.
  `GBFS_ASSERT_ALWAYS(a_tail_bound, tail_q <= LP_W'(CELL_COUNT), "queue overflow")
  // A search is only launched while the sequencer is idle.
  `GBFS_ASSERT_SAME(a_go_idle, go_i.go, state_q == S_IDLE, "search launched while busy")
  // Reaching the end cell finishes the search with a found result.
  `GBFS_ASSERT_NEXT(a_end_done, hit_end, res_o.done && found_q, "end reached but no result")

endmodule

/* rtl/grid_bfs_shortest_path.sv */
// Top level of the grid shortest path search: config registers, cell loader, result output.
// Depends on gbfs_pkg, gbfs_search and gbfs_step.
//
// Usage: cells arrive on the slave stream in row-major order, one per item, cell kind in
// s_axis_tdata[1:0]; s_axis_tlast marks the last cell and starts the search. Cells past
// rows*cols are dropped, though their tlast still counts. Non-last cells are taken back
// to back. After the last cell, s_axis_tready drops until the result has moved into the
// output register. The sequencer splits the start index into row and column, then tries
// the four directions of each dequeued cell: one off the grid or past the loaded cells
// fails in the single step unit, one inside is read from the registered free-cell map.
// A grid without a usable start or end skips the search and answers via the pending
// result register. The master stream carries one item per grid: reachable in bit 0,
// path_cost in bits 28:1. The output register holds a result while m_axis_tready is low,
// and loading of the next grid may go on meanwhile. Reset clears the loader, drops any
// pending result and restores grid_cols 64, grid_rows 64 and step_cost 1; no clearing
// pass is needed. Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i
// by the user only while idle, a rule that the block itself does not enforce.
module grid_bfs_shortest_path import gbfs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port.
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // Cell stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [1:0] cell_kind, rest zero
  input  logic                   s_axis_tlast,  // last_cell
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [0] reachable, [28:1] path_cost, rest zero
);

  localparam int TOT_W  = ROWC_W + COLC_W;
  localparam int CMP_W  = (TOT_W > LP_W) ? TOT_W : LP_W;
  localparam int PROD_W = IDX_W + COST_W;
  localparam int PAD_W  = OUT_TDATA_W - PCOST_W - 1;

  logic [SIZE_W-1:0]      grid_cols_q;
  logic [SIZE_W-1:0]      grid_rows_q;
  logic [COST_W-1:0]      step_cost_q;
  logic [LP_W-1:0]        load_pos_q;
  logic                   start_vld_q;
  logic [IDX_W-1:0]       start_idx_q;
  logic                   end_vld_q;
  logic [IDX_W-1:0]       end_idx_q;
  logic                   busy_q;
  logic                   pend_q;
  logic                   pend_found_q;
  logic [IDX_W-1:0]       pend_dist_q;
  logic                   m_tvalid_q;
  logic [OUT_TDATA_W-1:0] m_tdata_q;

  logic [ROWC_W-1:0]      rows_c;
  logic [COLC_W-1:0]      cols_c;
  logic [TOT_W-1:0]       total;
  cell_kind_e             kind;
  logic                   in_acc;
  logic                   load_now;
  logic                   start_vld_d;
  logic [IDX_W-1:0]       start_idx_d;
  logic                   end_vld_d;
  logic [IDX_W-1:0]       end_idx_d;
  logic [LP_W-1:0]        load_pos_d;
  logic                   search_ok;
  logic                   out_load;
  logic [PCOST_W-1:0]     path_cost;
  ld_wr_t                 ld_wr;
  go_t                    go;
  res_t                   res;

  // Grid sizes in use: zero counts as one, oversize counts as the maximum.
  always_comb begin
    if (grid_rows_q == '0) begin
      rows_c = ROWC_W'(1);
    end else if (32'(grid_rows_q) > MAX_ROWS) begin
      rows_c = ROWC_W'(MAX_ROWS);
    end else begin
      rows_c = ROWC_W'(grid_rows_q);
    end
    if (grid_cols_q == '0) begin
      cols_c = COLC_W'(1);
    end else if (32'(grid_cols_q) > MAX_COLS) begin
      cols_c = COLC_W'(MAX_COLS);
    end else begin
      cols_c = COLC_W'(grid_cols_q);
    end
  end

  assign total = TOT_W'(rows_c) * TOT_W'(cols_c);

  // Loader: next values of the position and the start and end marks.
  assign kind          = cell_kind_e'(s_axis_tdata[1:0]);
  assign s_axis_tready = !busy_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign load_now      = in_acc && (CMP_W'(load_pos_q) < CMP_W'(total));

  always_comb begin
    start_vld_d = start_vld_q;
    start_idx_d = start_idx_q;
    end_vld_d   = end_vld_q;
    end_idx_d   = end_idx_q;
    load_pos_d  = load_pos_q;
    if (load_now) begin
      load_pos_d = load_pos_q + LP_W'(1);
      if (kind == KIND_START) begin
        start_vld_d = 1'b1;
        start_idx_d = load_pos_q[IDX_W-1:0];
      end
      if (kind == KIND_END) begin
        end_vld_d = 1'b1;
        end_idx_d = load_pos_q[IDX_W-1:0];
      end
    end
  end

  // A search needs both marks inside the grid in use and among the loaded cells.
  assign search_ok = start_vld_d && end_vld_d
                  && (CMP_W'(start_idx_d) < CMP_W'(total))
                  && (CMP_W'(end_idx_d) < CMP_W'(total))
                  && (LP_W'(start_idx_d) < load_pos_d)
                  && (LP_W'(end_idx_d) < load_pos_d);

  assign ld_wr = '{en: load_now, addr: load_pos_q[IDX_W-1:0], open: (kind != KIND_WALL)};
  assign go    = '{go: in_acc && s_axis_tlast && search_ok, start_idx: start_idx_d,
                   end_idx: end_idx_d, limit: load_pos_d, rows: rows_c, cols: cols_c};

  gbfs_search u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ld_i   (ld_wr),
    .go_i   (go),
    .res_o  (res)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= GRID_SIZE_RST;
      grid_rows_q <= GRID_SIZE_RST;
      step_cost_q <= STEP_COST_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_COLS: grid_cols_q <= cfg_data_i[SIZE_W-1:0];
        REG_GRID_ROWS: grid_rows_q <= cfg_data_i[SIZE_W-1:0];
        REG_STEP_COST: step_cost_q <= cfg_data_i[COST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Loader state, search handoff and pending result.
  assign out_load  = pend_q && (!m_tvalid_q || m_axis_tready);
  assign path_cost = PCOST_W'(PROD_W'(pend_dist_q) * PROD_W'(step_cost_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pos_q   <= '0;
      start_vld_q  <= 1'b0;
      start_idx_q  <= '0;
      end_vld_q    <= 1'b0;
      end_idx_q    <= '0;
      busy_q       <= 1'b0;
      pend_q       <= 1'b0;
      pend_found_q <= 1'b0;
      pend_dist_q  <= '0;
      m_tvalid_q   <= 1'b0;
    end else begin
      if (in_acc && s_axis_tlast) begin
        load_pos_q  <= '0;
        start_vld_q <= 1'b0;
        start_idx_q <= '0;
        end_vld_q   <= 1'b0;
        end_idx_q   <= '0;
        busy_q      <= 1'b1;
        if (!search_ok) begin
          pend_q       <= 1'b1;
          pend_found_q <= 1'b0;
          pend_dist_q  <= '0;
        end
      end else begin
        load_pos_q  <= load_pos_d;
        start_vld_q <= start_vld_d;
        start_idx_q <= start_idx_d;
        end_vld_q   <= end_vld_d;
        end_idx_q   <= end_idx_d;
      end
      if (res.done) begin
        pend_q       <= 1'b1;
        pend_found_q <= res.found;
        pend_dist_q  <= res.found ? res.steps : '0;
      end
      if (out_load) begin
        pend_q     <= 1'b0;
        busy_q     <= 1'b0;
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // Output register: the step count times the cost goes straight into it.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_tdata_q <= {PAD_W'(0), path_cost, pend_found_q};
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

endmodule

/* tb/grid_bfs_shortest_path_tb.sv */
// Self-checking testbench for grid_bfs_shortest_path: streams grids of cells in, checks
// every search result against an in-bench breadth-first search of the same grid.
// Depends on gbfs_pkg and the grid_bfs_shortest_path RTL.
module grid_bfs_shortest_path_tb import gbfs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any accepted item before the run is declared hung. The slowest
  // search here covers at most 256 loaded cells.
  localparam int STALL_LIMIT = 20000;
  localparam int CELL_TARGET = 1750;

  typedef struct packed {
    cell_kind_e kind;
    logic       last;
  } cell_item_t;

  typedef struct packed {
    logic               reachable;
    logic [PCOST_W-1:0] path_cost;
  } path_result_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [1:0] cell_kind, rest zero
  logic                   s_axis_tlast = 1'b0; // last_cell
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [0] reachable, [28:1] path_cost, rest zero

  grid_bfs_shortest_path dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the registers and of the loader state.
  logic [SIZE_W-1:0] cols_cfg = 7'd64;
  logic [SIZE_W-1:0] rows_cfg = 7'd64;
  logic [COST_W-1:0] cost_cfg = 16'd1;
  bit                cell_open [CELL_COUNT];
  int unsigned       load_pos = 0;
  int unsigned       start_at = 0;
  int unsigned       end_at = 0;
  bit                start_set = 1'b0;
  bit                end_set = 1'b0;

  // Working storage of the search.
  bit          bfs_seen  [CELL_COUNT];
  int unsigned bfs_steps [CELL_COUNT];
  int unsigned bfs_fifo  [CELL_COUNT];

  cell_item_t   cell_q[$];
  path_result_t path_results_due[$];
  int unsigned  cells_pushed = 0;
  int unsigned  cells_taken = 0;
  int unsigned  failures = 0;

  // Size register as the block uses it: zero counts as one, large values saturate.
  function automatic int eff_size(input logic [SIZE_W-1:0] raw, input int cap);
    if (raw == 0) return 1;
    if (raw > cap) return cap;
    return int'(raw);
  endfunction

  // Shortest path from the recorded start to the recorded end over the loaded cells.
  function automatic void run_bfs(input int rows, input int cols,
                                  output logic hit, output logic [PCOST_W-1:0] cost);
    int unsigned total, head, tail, cur, idx, k;
    int r, c, nr, nc;
    dir_e way;
    logic [63:0] product;
    hit = 1'b0;
    cost = '0;
    total = rows * cols;
    if (!start_set || !end_set) return;
    if (start_at >= total || end_at >= total) return;
    if (start_at >= load_pos || end_at >= load_pos) return;
    for (k = 0; k < CELL_COUNT; k++) bfs_seen[k] = 1'b0;
    head = 0;
    tail = 1;
    bfs_seen[start_at] = 1'b1;
    bfs_steps[start_at] = 0;
    bfs_fifo[0] = start_at;
    while (head < tail) begin
      cur = bfs_fifo[head];
      head++;
      if (cur == end_at) break;
      r = cur / cols;
      c = cur % cols;
      for (k = 0; k < 4; k++) begin
        way = dir_e'(k);
        nr = r;
        nc = c;
        case (way)
          DIR_DOWN:  nr = r + 1;
          DIR_RIGHT: nc = c + 1;
          DIR_UP:    nr = r - 1;
          default:   nc = c - 1;
        endcase
        if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) continue;
        idx = nr * cols + nc;
        if (idx >= load_pos) continue;
        if (!cell_open[idx] || bfs_seen[idx]) continue;
        bfs_seen[idx] = 1'b1;
        bfs_steps[idx] = bfs_steps[cur] + 1;
        if (tail < CELL_COUNT) begin
          bfs_fifo[tail] = idx;
          tail++;
        end
      end
    end
    if (bfs_seen[end_at]) begin
      hit = 1'b1;
      product = 64'(bfs_steps[end_at]) * 64'(cost_cfg);
      cost = product[PCOST_W-1:0];
    end
  endfunction

  // Loads one accepted cell; the last cell of a grid yields the expected result.
  function automatic void absorb_cell(input cell_kind_e kind, input logic last);
    int cols, rows;
    int unsigned total;
    logic hit;
    logic [PCOST_W-1:0] cost;
    cols = eff_size(cols_cfg, MAX_COLS);
    rows = eff_size(rows_cfg, MAX_ROWS);
    total = cols * rows;
    if (load_pos < total) begin
      cell_open[load_pos] = (kind != KIND_WALL);
      if (kind == KIND_START) begin
        start_at = load_pos;
        start_set = 1'b1;
      end
      if (kind == KIND_END) begin
        end_at = load_pos;
        end_set = 1'b1;
      end
      load_pos++;
    end
    if (last) begin
      run_bfs(rows, cols, hit, cost);
      path_results_due.push_back('{reachable: hit, path_cost: cost});
      load_pos = 0;
      start_set = 1'b0;
      end_set = 1'b0;
    end
  endfunction

  function automatic void push_cell(input cell_kind_e kind, input logic last);
    cell_q.push_back('{kind: kind, last: last});
    cells_pushed++;
  endfunction

  // Queues one grid. Most grids are well formed; the rest lack a mark, carry extra
  // marks, are pure noise, stop early or run past the grid size.
  function automatic void queue_grid(input int unsigned total);
    int unsigned variant, loaded, n, s_at, e_at, x_at, density, i;
    cell_kind_e kind;
    variant = $urandom_range(0, 99);
    // Full-size grids are far too long to stream, so those stop after a few rows.
    loaded = (total > 256) ? $urandom_range(1, 160) : total;
    n = loaded;
    if (variant >= 92) n = loaded + $urandom_range(1, 4);
    else if (variant >= 85 && loaded > 1) n = $urandom_range(1, loaded - 1);
    density = $urandom_range(55, 95);
    s_at = $urandom_range(0, loaded - 1);
    e_at = $urandom_range(0, loaded - 1);
    if (e_at == s_at && loaded > 1) e_at = (s_at + 1 + $urandom_range(0, loaded - 2)) % loaded;
    x_at = $urandom_range(0, loaded - 1);
    for (i = 0; i < n; i++) begin
      if (i >= loaded || (variant >= 75 && variant < 80)) kind = cell_kind_e'($urandom_range(0, 3));
      else if (i == s_at && !(variant >= 65 && variant < 70)) kind = KIND_START;
      else if (i == e_at && !(variant >= 70 && variant < 75)) kind = KIND_END;
      else if (i == x_at && variant >= 80 && variant < 85)
        kind = $urandom_range(0, 1) ? KIND_START : KIND_END;
      else if ($urandom_range(1, 100) <= density) kind = KIND_OPEN;
      else kind = KIND_WALL;
      push_cell(kind, i == n - 1);
    end
  endfunction

  // Writes all three registers on consecutive edges, then drops the write enable.
  task automatic configure(input logic [CFG_DATA_W-1:0] cols_raw,
                           input logic [CFG_DATA_W-1:0] rows_raw,
                           input logic [CFG_DATA_W-1:0] cost_raw);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_GRID_COLS;
    cfg_data_i <= cols_raw;
    cols_cfg = cols_raw[SIZE_W-1:0];
    @(posedge clk_i);
    cfg_idx_i <= REG_GRID_ROWS;
    cfg_data_i <= rows_raw;
    rows_cfg = rows_raw[SIZE_W-1:0];
    @(posedge clk_i);
    cfg_idx_i <= REG_STEP_COST;
    cfg_data_i <= cost_raw;
    cost_cfg = cost_raw[COST_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every queued cell is taken and every result has come back, then lets
  // the last plain cell settle in the loader.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (cells_taken != cells_pushed || path_results_due.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // Cell driver: bursts of random length separated by random gaps.
  int         burst_left;
  int         gap_left;
  cell_item_t next_cell;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tlast <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_cell(cell_kind_e'(s_axis_tdata[1:0]), s_axis_tlast);
        cells_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0 || cell_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_axis_tvalid <= 1'b0;
        end else begin
          next_cell = cell_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= IN_TDATA_W'(next_cell.kind);
          s_axis_tlast <= next_cell.last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 48);
            case ($urandom_range(0, 4))
              0, 1:    gap_left = 0;
              2, 3:    gap_left = $urandom_range(1, 4);
              default: gap_left = $urandom_range(5, 30);
            endcase
          end
        end
      end
    end
  end

  // Result monitor and checker; the receiver switches between stall patterns.
  rx_mode_e     rx_mode;
  int           rx_left;
  int unsigned  rx_beat;
  logic         ready_next;
  path_result_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_mode = RX_OPEN;
      rx_left = 0;
      rx_beat = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (path_results_due.size() == 0) begin
          $error("result item with none expected: tdata %h", m_axis_tdata);
          failures++;
        end else begin
          want = path_results_due.pop_front();
          if (m_axis_tdata[0] !== want.reachable) begin
            $error("reachable: expected %0d, actual %0d", want.reachable, m_axis_tdata[0]);
            failures++;
          end
          if (m_axis_tdata[PCOST_W:1] !== want.path_cost) begin
            $error("path_cost: expected %0d, actual %0d", want.path_cost,
                   m_axis_tdata[PCOST_W:1]);
            failures++;
          end
        end
      end
      rx_beat++;
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 160);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN:   ready_next = 1'b1;
        RX_COIN:   ready_next = $urandom_range(0, 1);
        RX_SPARSE: ready_next = ($urandom_range(0, 6) == 0);
        default:   ready_next = (rx_beat % 5) < 2;
      endcase
      m_axis_tready <= ready_next;
    end
  end

  // Watchdog on handshake progress.
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus: directed grids first, then random phases each with its own sizes.
  initial begin
    int unsigned total, grids_left, i, n_prefix;
    logic [CFG_DATA_W-1:0] cols_raw, rows_raw, cost_raw;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset sizes, grid cut short: end two cells right of the start.
    push_cell(KIND_START, 1'b0);
    push_cell(KIND_OPEN, 1'b0);
    push_cell(KIND_END, 1'b1);
    // A lone wall has neither start nor end.
    push_cell(KIND_WALL, 1'b1);
    wait_idle();

    // 2x2 at the largest cost: a path around a wall, repeated marks,
    // a missing end, and cells past the grid size.
    configure(16'd2, 16'd2, 16'hFFFF);
    push_cell(KIND_START, 1'b0);
    push_cell(KIND_WALL, 1'b0);
    push_cell(KIND_OPEN, 1'b0);
    push_cell(KIND_END, 1'b1);
    push_cell(KIND_START, 1'b0);
    push_cell(KIND_START, 1'b0);
    push_cell(KIND_END, 1'b0);
    push_cell(KIND_END, 1'b1);
    push_cell(KIND_START, 1'b0);
    push_cell(KIND_OPEN, 1'b1);
    push_cell(KIND_START, 1'b0);
    push_cell(KIND_END, 1'b0);
    push_cell(KIND_WALL, 1'b0);
    push_cell(KIND_WALL, 1'b0);
    push_cell(KIND_END, 1'b0);
    push_cell(KIND_OPEN, 1'b1);
    wait_idle();

    // Zero columns count as one, rows past the maximum saturate, zero cost.
    configure(16'd0, 16'd127, 16'd0);
    push_cell(KIND_START, 1'b0);
    push_cell(KIND_OPEN, 1'b0);
    push_cell(KIND_END, 1'b1);
    wait_idle();

    // Sizes change halfway through a grid; the search uses the final sizes.
    configure(16'd1, 16'd64, 16'd3);
    push_cell(KIND_START, 1'b0);
    push_cell(KIND_OPEN, 1'b0);
    wait_idle();
    configure(16'd2, 16'd2, 16'd3);
    push_cell(KIND_END, 1'b1);
    wait_idle();

    // Random phases.
    while (cells_pushed < CELL_TARGET) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3, 4, 5: begin
          cols_raw = $urandom_range(1, 8);
          rows_raw = $urandom_range(1, 8);
        end
        6, 7: begin
          cols_raw = $urandom_range(1, 16);
          rows_raw = $urandom_range(1, 16);
        end
        8: begin
          cols_raw = $urandom_range(33, 64);
          rows_raw = $urandom_range(1, 3);
        end
        9: begin
          cols_raw = $urandom_range(1, 3);
          rows_raw = $urandom_range(33, 64);
        end
        10: begin
          // Out-of-range sizes with junk above the register width.
          cols_raw = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(65, 127));
          rows_raw = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(65, 127));
          cols_raw[CFG_DATA_W-1:SIZE_W] = $urandom_range(0, 511);
          rows_raw[CFG_DATA_W-1:SIZE_W] = $urandom_range(0, 511);
        end
        default: begin
          cols_raw = 16'd64;
          rows_raw = 16'd64;
        end
      endcase
      case ($urandom_range(0, 5))
        0:       cost_raw = 16'd0;
        1:       cost_raw = 16'hFFFF;
        2:       cost_raw = 16'd1;
        default: cost_raw = $urandom_range(0, 65535);
      endcase
      configure(cols_raw, rows_raw, cost_raw);
      total = eff_size(cols_cfg, MAX_COLS) * eff_size(rows_cfg, MAX_ROWS);
      grids_left = $urandom_range(1, 5);
      repeat (grids_left) queue_grid(total);
      // Now and then leave a grid half loaded across the next size change.
      if ($urandom_range(0, 7) == 0 && cells_pushed < CELL_TARGET - 50) begin
        n_prefix = $urandom_range(1, 6);
        for (i = 0; i < n_prefix; i++) push_cell(cell_kind_e'($urandom_range(0, 3)), 1'b0);
      end
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (failures == 0 && path_results_due.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/gbfs_pkg.sv
rtl/gbfs_step.sv
rtl/gbfs_search.sv
rtl/grid_bfs_shortest_path.sv
tb/grid_bfs_shortest_path_tb.sv
